// ----- src/sla_pkg.sv -----
package sla_pkg;

    localparam int DivSteps = 64;

    typedef enum logic [4:0] {
        ACT_MOV    = 5'd0,
        ACT_ADD    = 5'd1,
        ACT_SUB    = 5'd2,
        ACT_MUL    = 5'd3,
        ACT_DIV    = 5'd4,
        ACT_REM    = 5'd5,
        ACT_AND    = 5'd6,
        ACT_OR     = 5'd7,
        ACT_XOR    = 5'd8,
        ACT_SHL    = 5'd9,
        ACT_SHR    = 5'd10,
        ACT_MIN    = 5'd11,
        ACT_MAX    = 5'd12,
        ACT_ADDF32 = 5'd13,
        ACT_FMA    = 5'd14,
        ACT_SELECT = 5'd15,
        ACT_CMPLT  = 5'd16,
        ACT_CMPEQ  = 5'd17,
        ACT_CMPGE  = 5'd18,
        ACT_CMPGT  = 5'd19
    } action_t;

    typedef struct packed {
        logic [4:0]  action;
        logic        active;
        logic        sel;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] dvs;
        logic        qneg;
        logic        rneg;
    } div_t;

    function automatic logic [63:0] abs64(input logic [63:0] v);
        abs64 = v[63] ? (~v + 64'd1) : v;
    endfunction

endpackage

// ----- src/simd_lane_integer_alu.sv -----
// One integer ALU lane of a vector unit.
// Input channel: in_valid / in_stall carry action, lane_active, select_bit
// and operand_a/b/c. Output channel: out_valid / out_stall carry
// lane_value, write_enable and compare_bit, one result per transfer.
// The lane is a row of 64 identical divider cells, one quotient bit per
// cell, followed by a four-stage tail that finishes multiply, fma, binary32
// add and the final selection. Every item walks the whole row and then the
// tail; one item is taken per cycle unless a stall at the output backs up.
// Each stage holds its own valid bit and loads whenever it is empty or its
// neighbor moves on, so bubbles close up and a stalled result at the output
// does not stop earlier stages from filling.
// in_stall rises only once every stage holds an item and out_stall is high.
// Reset clears all valid bits; no result is presented until items arrive.
module simd_lane_integer_alu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  action,
    input  logic        lane_active,
    input  logic        select_bit,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic [63:0] operand_c,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] lane_value,
    output logic        write_enable,
    output logic        compare_bit
);

    sla_pkg::div_t cv [0:sla_pkg::DivSteps];
    logic          vv [0:sla_pkg::DivSteps];
    logic          rd [0:sla_pkg::DivSteps];
    sla_pkg::div_t head_item;

    always_comb
    begin
        head_item.action = action;
        head_item.active = lane_active;
        head_item.sel    = select_bit;
        head_item.a      = operand_a;
        head_item.b      = operand_b;
        head_item.c      = operand_c;
        head_item.rem    = 64'd0;
        head_item.quo    = sla_pkg::abs64(operand_a);
        head_item.dvs    = sla_pkg::abs64(operand_b);
        head_item.qneg   = operand_a[63] ^ operand_b[63];
        head_item.rneg   = operand_a[63];
    end

    assign cv[0]    = head_item;
    assign vv[0]    = in_valid;
    assign in_stall = !rd[0];

    for (genvar i = 0; i < sla_pkg::DivSteps; i++)
    begin : g_cell
        sla_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vv[i]),
            .in_item   (cv[i]),
            .in_ready  (rd[i]),
            .out_valid (vv[i+1]),
            .out_item  (cv[i+1]),
            .out_ready (rd[i+1])
        );
    end

    sla_tail u_tail (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (vv[sla_pkg::DivSteps]),
        .in_item      (cv[sla_pkg::DivSteps]),
        .in_ready     (rd[sla_pkg::DivSteps]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .lane_value   (lane_value),
        .write_enable (write_enable),
        .compare_bit  (compare_bit)
    );

`ifndef ASSERT_OFF
    a_we_cb_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable |-> !compare_bit)
        else $error("write enable and compare bit both set");

    a_no_we_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> lane_value == 64'd0)
        else $error("nonzero value without write enable");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output drains");
`endif

endmodule

// ----- src/sla_div_cell.sv -----
module sla_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  sla_pkg::div_t in_item,
    output logic          in_ready,
    output logic          out_valid,
    output sla_pkg::div_t out_item,
    input  logic          out_ready
);

    logic          valid_reg;
    sla_pkg::div_t item_reg;
    sla_pkg::div_t item_next;
    logic [63:0]   rem_shift;
    logic [63:0]   quo_shift;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // one restoring step: shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        item_next = in_item;
        rem_shift = {in_item.rem[62:0], in_item.quo[63]};
        quo_shift = {in_item.quo[62:0], 1'b0};
        if (rem_shift >= in_item.dvs)
        begin
            item_next.rem = rem_shift - in_item.dvs;
            item_next.quo = quo_shift | 64'd1;
        end
        else
        begin
            item_next.rem = rem_shift;
            item_next.quo = quo_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- src/sla_tail.sv -----
module sla_tail (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  sla_pkg::div_t in_item,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [63:0]   lane_value,
    output logic          write_enable,
    output logic          compare_bit
);

    typedef struct packed {
        logic [4:0]  action;
        logic        active;
        logic        we;
        logic        cb;
        logic [63:0] val;
        logic [63:0] c;
        logic [63:0] p0;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [63:0] prod;
        logic        fspec;
        logic [31:0] fspecv;
        logic        fsign;
        logic [8:0]  fe;
        logic [30:0] fma;
        logic [30:0] fmb;
        logic        fsub;
        logic [31:0] fm;
        logic [4:0]  fsh;
        logic        fzero;
    } tl_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;
    tl_t  s1_reg, s2_reg, s3_reg, s4_reg;
    tl_t  s1_next, s2_next, s3_next, s4_next;

    logic [63:0] a, b;
    logic        bz;
    logic        sa, sb;
    logic [7:0]  ea, eb, ea1, eb1, el, es, dd;
    logic [22:0] fa, fb;
    logic [30:0] ma0, mb0, mlg, msm;
    logic        swap;
    logic [5:0]  dcap;
    logic [70:0] ext;
    logic        za, zb;

    logic [30:0] m1;
    logic [8:0]  e1;
    logic [4:0]  lz;
    logic [30:0] m2;
    logic [8:0]  e2;
    logic [6:0]  rb;
    logic [24:0] mr;
    logic [7:0]  ef;
    logic [31:0] fres;

    assign r4       = !v4_reg || !out_stall;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    assign out_valid    = v4_reg;
    assign lane_value   = s4_reg.val;
    assign write_enable = s4_reg.we;
    assign compare_bit  = s4_reg.cb;

    // simple ops, divider fixup, partial products, float unpack and align
    always_comb
    begin
        s1_next = '0;
        a  = in_item.a;
        b  = in_item.b;
        bz = (b == 64'd0);
        s1_next.action = in_item.action;
        s1_next.active = in_item.active;
        s1_next.c      = in_item.c;
        s1_next.we     = in_item.active && (in_item.action <= sla_pkg::ACT_SELECT);
        unique case (in_item.action)
            sla_pkg::ACT_MOV:    s1_next.val = a;
            sla_pkg::ACT_ADD:    s1_next.val = a + b;
            sla_pkg::ACT_SUB:    s1_next.val = a - b;
            sla_pkg::ACT_DIV:
                s1_next.val = bz ? 64'd0 : (in_item.qneg ? -in_item.quo : in_item.quo);
            sla_pkg::ACT_REM:
                s1_next.val = bz ? 64'd0 : (in_item.rneg ? -in_item.rem : in_item.rem);
            sla_pkg::ACT_AND:    s1_next.val = a & b;
            sla_pkg::ACT_OR:     s1_next.val = a | b;
            sla_pkg::ACT_XOR:    s1_next.val = a ^ b;
            sla_pkg::ACT_SHL:    s1_next.val = a << b[5:0];
            sla_pkg::ACT_SHR:    s1_next.val = a >> b[5:0];
            sla_pkg::ACT_MIN:    s1_next.val = ($signed(b) < $signed(a)) ? b : a;
            sla_pkg::ACT_MAX:    s1_next.val = ($signed(a) < $signed(b)) ? b : a;
            sla_pkg::ACT_SELECT: s1_next.val = in_item.sel ? a : b;
            sla_pkg::ACT_CMPLT:  s1_next.cb = ($signed(a) < $signed(b));
            sla_pkg::ACT_CMPEQ:  s1_next.cb = (a == b);
            sla_pkg::ACT_CMPGE:  s1_next.cb = !($signed(a) < $signed(b));
            sla_pkg::ACT_CMPGT:  s1_next.cb = ($signed(b) < $signed(a));
            default:             s1_next.val = 64'd0;
        endcase
        if (!in_item.active)
        begin
            s1_next.val = 64'd0;
            s1_next.cb  = 1'b0;
        end

        s1_next.p0 = a[31:0] * b[31:0];
        s1_next.p1 = 32'(a[31:0] * b[63:32]);
        s1_next.p2 = 32'(a[63:32] * b[31:0]);

        sa = a[31];
        sb = b[31];
        ea = a[30:23];
        eb = b[30:23];
        fa = a[22:0];
        fb = b[22:0];
        za = (ea == 8'd0) && (fa == 23'd0);
        zb = (eb == 8'd0) && (fb == 23'd0);
        s1_next.fspec = 1'b1;
        if (ea == 8'hFF && fa != 23'd0)
            s1_next.fspecv = a[31:0] | 32'h0040_0000;
        else if (eb == 8'hFF && fb != 23'd0)
            s1_next.fspecv = b[31:0] | 32'h0040_0000;
        else if (ea == 8'hFF)
            s1_next.fspecv = (eb == 8'hFF && sa != sb) ? 32'hFFC0_0000 : a[31:0];
        else if (eb == 8'hFF)
            s1_next.fspecv = b[31:0];
        else if (za)
            s1_next.fspecv = zb ? {sa & sb, 31'd0} : b[31:0];
        else if (zb)
            s1_next.fspecv = a[31:0];
        else
        begin
            s1_next.fspec  = 1'b0;
            s1_next.fspecv = 32'd0;
        end

        ma0  = {(ea != 8'd0), fa, 7'd0};
        mb0  = {(eb != 8'd0), fb, 7'd0};
        ea1  = (ea == 8'd0) ? 8'd1 : ea;
        eb1  = (eb == 8'd0) ? 8'd1 : eb;
        swap = (eb1 > ea1) || (eb1 == ea1 && mb0 > ma0);
        el   = swap ? eb1 : ea1;
        es   = swap ? ea1 : eb1;
        mlg  = swap ? mb0 : ma0;
        msm  = swap ? ma0 : mb0;
        dd   = el - es;
        dcap = (dd > 8'd40) ? 6'd40 : dd[5:0];
        ext  = {msm, 40'd0} >> dcap;
        s1_next.fsign = swap ? sb : sa;
        s1_next.fe    = {1'b0, el};
        s1_next.fma   = mlg;
        s1_next.fmb   = ext[70:40] | {30'd0, (ext[39:0] != 40'd0)};
        s1_next.fsub  = (sa != sb);
    end

    // low product sum and mantissa add
    always_comb
    begin
        s2_next      = s1_reg;
        s2_next.prod = s1_reg.p0 + {s1_reg.p1 + s1_reg.p2, 32'd0};
        s2_next.fm   = s1_reg.fsub ? ({1'b0, s1_reg.fma} - {1'b0, s1_reg.fmb})
                                   : ({1'b0, s1_reg.fma} + {1'b0, s1_reg.fmb});
    end

    // multiply result, float carry fold and leading zero count
    always_comb
    begin
        s3_next = s2_reg;
        if (s2_reg.active && s2_reg.action == sla_pkg::ACT_MUL)
            s3_next.val = s2_reg.prod;
        else if (s2_reg.active && s2_reg.action == sla_pkg::ACT_FMA)
            s3_next.val = s2_reg.prod + s2_reg.c;
        s3_next.fzero = (s2_reg.fm == 32'd0);
        if (s2_reg.fm[31])
        begin
            m1 = {s2_reg.fm[31:2], s2_reg.fm[1] | s2_reg.fm[0]};
            e1 = s2_reg.fe + 9'd1;
        end
        else
        begin
            m1 = s2_reg.fm[30:0];
            e1 = s2_reg.fe;
        end
        lz = 5'd0;
        for (int i = 0; i < 31; i++)
        begin
            if (m1[i])
                lz = 5'(30 - i);
        end
        s3_next.fm  = {1'b0, m1};
        s3_next.fe  = e1;
        s3_next.fsh = ((e1 - 9'd1) < {4'd0, lz}) ? 5'(e1 - 9'd1) : lz;
    end

    // normalize, round and pack
    always_comb
    begin
        s4_next = s3_reg;
        m2 = s3_reg.fm[30:0] << s3_reg.fsh;
        e2 = s3_reg.fe - {4'd0, s3_reg.fsh};
        rb = m2[6:0];
        mr = {1'b0, m2[30:7]}
             + {24'd0, (rb > 7'h40) || (rb == 7'h40 && m2[7])};
        if (mr[24])
        begin
            mr = mr >> 1;
            e2 = e2 + 9'd1;
        end
        ef = mr[23] ? e2[7:0] : 8'd0;
        if (e2 >= 9'd255)
            fres = {s3_reg.fsign, 8'hFF, 23'd0};
        else
            fres = {s3_reg.fsign, ef, mr[22:0]};
        if (s3_reg.fspec)
            fres = s3_reg.fspecv;
        else if (s3_reg.fzero)
            fres = 32'd0;
        if (s3_reg.active && s3_reg.action == sla_pkg::ACT_ADDF32)
            s4_next.val = {32'd0, fres};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid) s1_reg <= s1_next;
        if (r2 && v1_reg)   s2_reg <= s2_next;
        if (r3 && v2_reg)   s3_reg <= s3_next;
        if (r4 && v3_reg)   s4_reg <= s4_next;
    end

endmodule
